[hw/rtl/ptl_pkg.sv]
`timescale 1ns / 1ps
package ptl_pkg;

	// default and ceiling for the working width of the value
	localparam int VALUE_WIDTH_DEF = 8;
	// fixed widths of the request and result fields
	localparam int VALUE_FIELD_W   = 8;
	localparam int NUMBER_FIELD_W  = 8;

	// command codes
	localparam logic CMD_TEST = 1'b0;
	localparam logic CMD_LIST = 1'b1;

	// divisor count at which a number is prime
	localparam logic [1:0] PRIME_DIV_COUNT = 2'd2;
	localparam logic [1:0] DIV_COUNT_SAT   = 2'd3;

	// controller to remainder unit
	typedef struct packed {
		logic start;
	} ptl_mod_req_t;

	// remainder unit to controller
	typedef struct packed {
		logic busy;
		logic done;
		logic rem_zero;
	} ptl_mod_rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CHECK = 5'b00010,
		ST_WAIT  = 5'b00100,
		ST_EVAL  = 5'b01000,
		ST_FINAL = 5'b10000
	} ptl_state_t;

endpackage

[hw/rtl/prime_test_and_list_top.sv]
`timescale 1ns / 1ps
// channel  | handshake             | payload
// request  | in_valid / in_ready   | cmd, value
// result   | out_valid / out_ready | number, prime_flag, last
//
// Test of n: each divisor d in 1..n is tried in turn on the shared remainder
// unit, and n is prime when exactly two of them leave no remainder.
// Listing up to n: each candidate p in 1..n is tested the same way.
// Reset (arst_n low) returns the sequencer to idle and drops out_valid.
// A stalled result holds the sequencer before the next result is loaded.
// in_ready is high only while idle; one request is worked at a time.
module prime_test_and_list_top import ptl_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      cmd,
	input  logic [VALUE_FIELD_W-1:0]  value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [NUMBER_FIELD_W-1:0] number,
	output logic                      prime_flag,
	output logic                      last
);

	ptl_mod_req_t           mod_req;
	ptl_mod_rsp_t           mod_rsp;
	logic [VALUE_WIDTH-1:0] mod_dividend;
	logic [VALUE_WIDTH-1:0] mod_divisor;

	// sequencer: walks candidates and divisors, counts exact divisors,
	// holds back one found prime so the last one can be marked
	ptl_ctrl #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.number       (number),
		.prime_flag   (prime_flag),
		.last         (last),
		.mod_req      (mod_req),
		.mod_dividend (mod_dividend),
		.mod_divisor  (mod_divisor),
		.mod_rsp      (mod_rsp)
	);

	// shared bit-serial remainder unit
	ptl_mod_unit #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (mod_req),
		.dividend (mod_dividend),
		.divisor  (mod_divisor),
		.rsp      (mod_rsp)
	);

endmodule

[hw/rtl/ptl_mod_unit.sv]
`timescale 1ns / 1ps
module ptl_mod_unit import ptl_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ptl_mod_req_t           req,
	input  logic [VALUE_WIDTH-1:0] dividend,
	input  logic [VALUE_WIDTH-1:0] divisor,
	output ptl_mod_rsp_t           rsp
);

	localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

	logic [VALUE_WIDTH-1:0] rem_q;
	logic [VALUE_WIDTH-1:0] sh_q;
	logic [VALUE_WIDTH-1:0] div_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [VALUE_WIDTH:0]   trial;
	logic [VALUE_WIDTH:0]   diff;

	// restoring remainder, one dividend bit per cycle
	assign trial = {rem_q, sh_q[VALUE_WIDTH-1]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(VALUE_WIDTH);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			sh_q  <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			sh_q <= {sh_q[VALUE_WIDTH-2:0], 1'b0};
			if (!diff[VALUE_WIDTH]) begin
				rem_q <= diff[VALUE_WIDTH-1:0];
			end else begin
				rem_q <= trial[VALUE_WIDTH-1:0];
			end
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.rem_zero = (rem_q == '0);

	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("remainder unit restarted while busy");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !req.start && cnt_q == CNT_W'(1)) |=> (done_q && !busy_q))
		else $error("remainder unit missed its done pulse");

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && div_q != '0) |-> (rem_q < div_q))
		else $error("remainder not below divisor");

endmodule

[hw/rtl/ptl_ctrl.sv]
`timescale 1ns / 1ps
module ptl_ctrl import ptl_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      cmd,
	input  logic [VALUE_FIELD_W-1:0]  value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [NUMBER_FIELD_W-1:0] number,
	output logic                      prime_flag,
	output logic                      last,
	output ptl_mod_req_t              mod_req,
	output logic [VALUE_WIDTH-1:0]    mod_dividend,
	output logic [VALUE_WIDTH-1:0]    mod_divisor,
	input  ptl_mod_rsp_t              mod_rsp
);

	ptl_state_t             state_q;
	logic                   cmd_q;
	logic [VALUE_WIDTH-1:0] n_q;
	logic [VALUE_WIDTH-1:0] p_q;
	logic [VALUE_WIDTH:0]   d_q;
	logic [1:0]             cnt_q;
	logic                   have_pend_q;
	logic [VALUE_WIDTH-1:0] pend_q;
	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] number_q;
	logic                   prime_q;
	logic                   last_q;

	logic [VALUE_WIDTH-1:0] val_in;
	logic                   slot_free;
	logic                   d_past_p;
	logic                   two_divisors;

	assign val_in       = value[VALUE_WIDTH-1:0];
	assign slot_free    = !out_valid_q || out_ready;
	assign d_past_p     = d_q > {1'b0, p_q};
	assign two_divisors = (cnt_q == PRIME_DIV_COUNT);

	assign in_ready      = (state_q == ST_IDLE);
	assign mod_req.start = (state_q == ST_CHECK) && !d_past_p;
	assign mod_dividend  = p_q;
	assign mod_divisor   = d_q[VALUE_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (cmd == CMD_LIST && val_in == '0) begin
							state_q <= ST_FINAL;
						end else begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					if (d_past_p) begin
						state_q <= ST_EVAL;
					end else begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (mod_rsp.done) begin
						state_q <= ST_CHECK;
					end
				end
				ST_EVAL: begin
					if (slot_free) begin
						if (cmd_q == CMD_TEST) begin
							out_valid_q <= 1'b1;
							state_q     <= ST_IDLE;
						end else begin
							if (two_divisors && have_pend_q) begin
								out_valid_q <= 1'b1;
							end
							if (p_q == n_q) begin
								state_q <= ST_FINAL;
							end else begin
								state_q <= ST_CHECK;
							end
						end
					end
				end
				ST_FINAL: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cmd_q       <= cmd;
				n_q         <= val_in;
				p_q         <= (cmd == CMD_TEST) ? val_in : VALUE_WIDTH'(1);
				d_q         <= (VALUE_WIDTH+1)'(1);
				cnt_q       <= '0;
				have_pend_q <= 1'b0;
			end
			ST_WAIT: begin
				if (mod_rsp.done) begin
					d_q <= d_q + 1'b1;
					if (mod_rsp.rem_zero && cnt_q != DIV_COUNT_SAT) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
			end
			ST_EVAL: begin
				if (slot_free) begin
					if (cmd_q == CMD_TEST) begin
						number_q <= p_q;
						prime_q  <= two_divisors;
						last_q   <= 1'b1;
					end else begin
						if (two_divisors) begin
							// earlier prime is now known not to be the last
							if (have_pend_q) begin
								number_q <= pend_q;
								prime_q  <= 1'b1;
								last_q   <= 1'b0;
							end
							pend_q      <= p_q;
							have_pend_q <= 1'b1;
						end
						p_q   <= p_q + 1'b1;
						d_q   <= (VALUE_WIDTH+1)'(1);
						cnt_q <= '0;
					end
				end
			end
			ST_FINAL: begin
				if (slot_free) begin
					number_q <= have_pend_q ? pend_q : '0;
					prime_q  <= have_pend_q;
					last_q   <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign number     = NUMBER_FIELD_W'(number_q);
	assign prime_flag = prime_q;
	assign last       = last_q;

endmodule

[test/tb_prime_test_and_list_top.sv]
`timescale 1ns / 1ps
module tb_prime_test_and_list_top import ptl_pkg::*;;

	// working width of the value, left at the block's default
	localparam int VW              = VALUE_WIDTH_DEF;
	localparam int RESET_CYCLES    = 11;
	localparam int RANDOM_REQUESTS = 267;
	// a test of 255 runs for less than this; wait it out before declaring
	// the block quiet
	localparam int DRAIN_CYCLES    = 3000;
	localparam int NUM_DIRECTED    = 23;

	// one result as seen on the output channel
	typedef struct packed {
		logic [NUMBER_FIELD_W-1:0] number;
		logic                      prime_flag;
		logic                      last;
	} prime_result_t;

	// one row of the directed table; where known_answer is set the single
	// result is typed in here, otherwise the trial-division predictor is used
	typedef struct packed {
		logic                     op;
		logic [VALUE_FIELD_W-1:0] value;
		logic                     known_answer;
		logic [NUMBER_FIELD_W-1:0] ans_number;
		logic                     ans_flag;
	} directed_row_t;

	logic                      clk        = 1'b0;
	logic                      arst_n     = 1'b0;
	logic                      in_valid   = 1'b0;
	logic                      in_ready;
	logic                      cmd        = CMD_TEST;
	logic [VALUE_FIELD_W-1:0]  value      = '0;
	logic                      out_valid;
	logic                      out_ready  = 1'b0;
	logic [NUMBER_FIELD_W-1:0] number;
	logic                      prime_flag;
	logic                      last;

	// results still owed by the block, oldest first
	prime_result_t pending_primes[$];
	int            mismatch_count = 0;
	// lengths of the remaining no-idle stretches on each side
	int            send_calm = 0;
	int            recv_calm = 0;

	// directed requests: extremes, both commands, zero and one, empty
	// listings, and the full listing up to 255 (most results per request)
	directed_row_t directed_rows [NUM_DIRECTED] = '{
		'{CMD_TEST,   8'd0, 1'b1,   8'd0, 1'b0},
		'{CMD_TEST,   8'd1, 1'b1,   8'd1, 1'b0},
		'{CMD_TEST,   8'd2, 1'b1,   8'd2, 1'b1},
		'{CMD_TEST, 8'd255, 1'b1, 8'd255, 1'b0},
		'{CMD_TEST,   8'd4, 1'b1,   8'd4, 1'b0},
		'{CMD_LIST,   8'd0, 1'b1,   8'd0, 1'b0},
		'{CMD_LIST,   8'd1, 1'b1,   8'd0, 1'b0},
		'{CMD_LIST,   8'd2, 1'b1,   8'd2, 1'b1},
		'{CMD_TEST,   8'd3, 1'b0,   8'd0, 1'b0},
		'{CMD_TEST, 8'd251, 1'b0,   8'd0, 1'b0},
		'{CMD_TEST, 8'd254, 1'b0,   8'd0, 1'b0},
		'{CMD_TEST, 8'd128, 1'b0,   8'd0, 1'b0},
		'{CMD_TEST, 8'd127, 1'b0,   8'd0, 1'b0},
		'{CMD_TEST, 8'd170, 1'b0,   8'd0, 1'b0},
		'{CMD_TEST,  8'd85, 1'b0,   8'd0, 1'b0},
		'{CMD_TEST,   8'd9, 1'b0,   8'd0, 1'b0},
		'{CMD_TEST,  8'd25, 1'b0,   8'd0, 1'b0},
		'{CMD_TEST, 8'd253, 1'b0,   8'd0, 1'b0},
		'{CMD_LIST,   8'd3, 1'b0,   8'd0, 1'b0},
		'{CMD_LIST,   8'd4, 1'b0,   8'd0, 1'b0},
		'{CMD_LIST,  8'd10, 1'b0,   8'd0, 1'b0},
		'{CMD_LIST,  8'd13, 1'b0,   8'd0, 1'b0},
		'{CMD_LIST, 8'd255, 1'b0,   8'd0, 1'b0}
	};

	prime_test_and_list_top #(
		.VALUE_WIDTH(VW)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.number    (number),
		.prime_flag(prime_flag),
		.last      (last)
	);

	// 4 ns period
	initial begin
		forever #2 clk = ~clk;
	end

	// hard stop, far beyond the slowest legal run
	initial begin
		#40_000_000;
		$display("FAILURE");
		$finish;
	end

	// prime exactly when n has two divisors in 1..n
	function automatic bit trial_says_prime(input int n);
		int divisors;
		divisors = 0;
		for (int d = 1; d <= n; d++) begin
			if (n % d == 0)
				divisors++;
		end
		return divisors == 2;
	endfunction

	// add one owed result at the tail of the queue
	function automatic void owe_result(input prime_result_t r);
		pending_primes = {pending_primes, r};
	endfunction

	// work out the results of one request and queue them
	function automatic void queue_prime_answers(input logic op, input logic [VALUE_FIELD_W-1:0] v);
		int            n;
		int            found;
		prime_result_t r;
		n = int'(v) & ((1 << VW) - 1);
		if (op == CMD_TEST) begin
			r.number     = NUMBER_FIELD_W'(n);
			r.prime_flag = trial_says_prime(n);
			r.last       = 1'b1;
			owe_result(r);
		end else begin
			found = 0;
			for (int p = 1; p <= n; p++) begin
				if (trial_says_prime(p)) begin
					r.number     = NUMBER_FIELD_W'(p);
					r.prime_flag = 1'b1;
					r.last       = 1'b0;
					owe_result(r);
					found++;
				end
			end
			if (found == 0) begin
				// empty listing: a single flag-clear result
				r.number     = '0;
				r.prime_flag = 1'b0;
				r.last       = 1'b1;
				owe_result(r);
			end else begin
				pending_primes[pending_primes.size() - 1].last = 1'b1;
			end
		end
	endfunction

	// idle cycles before the next handshake; now and then a run of
	// back-to-back handshakes with no idling at all
	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0)
			calm = $urandom_range(5, 25);
		return $urandom_range(0, 11);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// present one request and hold it until the block takes it; valid is
	// lowered only when a gap follows, so back-to-back requests keep it high
	task automatic send_request(input logic op, input logic [VALUE_FIELD_W-1:0] v,
			input logic known_answer, input logic [NUMBER_FIELD_W-1:0] ans_number,
			input logic ans_flag);
		int            gap;
		prime_result_t r;
		gap = draw_gap(send_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= op;
		value    <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		// request taken at this edge
		if (known_answer) begin
			r.number     = ans_number;
			r.prime_flag = ans_flag;
			r.last       = 1'b1;
			owe_result(r);
		end else begin
			queue_prime_answers(op, v);
		end
	endtask

	// request side: reset, directed table, then random requests
	initial begin
		logic                     op;
		logic [VALUE_FIELD_W-1:0] v;
		int                       pick;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++) begin
			send_request(directed_rows[i].op, directed_rows[i].value,
				directed_rows[i].known_answer, directed_rows[i].ans_number,
				directed_rows[i].ans_flag);
		end

		// random part: tests over the full range; listings kept short, since
		// a listing up to n tests every candidate in 1..n, with the odd
		// longer one
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			if ($urandom_range(0, 99) < 55) begin
				op = CMD_TEST;
				v  = VALUE_FIELD_W'($urandom_range(0, 255));
			end else begin
				op   = CMD_LIST;
				pick = $urandom_range(0, 99);
				if (pick < 5)
					v = VALUE_FIELD_W'($urandom_range(32, 90));
				else
					v = VALUE_FIELD_W'($urandom_range(0, 24));
			end
			send_request(op, v, 1'b0, '0, 1'b0);
		end
		in_valid <= 1'b0;

		// wait out every owed result, then a quiet spell for strays
		while (pending_primes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// result side: random stall before each result is taken
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = draw_gap(recv_calm);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	// compare every accepted result with the oldest one owed
	always @(posedge clk) begin : result_check
		prime_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_primes.size() == 0) begin
				report_mismatch("unexpected result number", int'(number), -1);
			end else begin
				want = pending_primes.pop_front();
				if (number !== want.number)
					report_mismatch("number", int'(number), int'(want.number));
				if (prime_flag !== want.prime_flag)
					report_mismatch("prime_flag", int'(prime_flag), int'(want.prime_flag));
				if (last !== want.last)
					report_mismatch("last", int'(last), int'(want.last));
			end
		end
	end

endmodule
